### src/acal_pkg.sv
// shared types and constants for the accelerometer calibration block
package acal_pkg;

  localparam int NumAxes   = 3;
  localparam int AxisW     = 2;
  localparam int LevelW    = 16;
  localparam int StepBits  = 4;
  localparam int DivSteps  = LevelW / StepBits;
  localparam int StepCntW  = $clog2(DivSteps);

  localparam logic signed [LevelW-1:0] LevelMax     = 16'sh7fff;
  localparam logic signed [LevelW-1:0] LevelMin     = 16'sh8000;
  localparam logic        [LevelW-1:0] DividerReset = 16'd1000;

  // configuration register indexes
  localparam logic [2:0] CfgOffsetX  = 3'd0;
  localparam logic [2:0] CfgOffsetY  = 3'd1;
  localparam logic [2:0] CfgOffsetZ  = 3'd2;
  localparam logic [2:0] CfgDividerX = 3'd3;
  localparam logic [2:0] CfgDividerY = 3'd4;
  localparam logic [2:0] CfgDividerZ = 3'd5;
  localparam logic [2:0] CfgEvents   = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABS,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } lane_ctl_t;

  typedef logic [NumAxes-1:0][LevelW-1:0] level_vec_t;

endpackage

### src/acal_lane.sv
// one axis lane: offset, scale by 32767, radix-16 division and saturation
module acal_lane (
  input  logic                     clk,
  input  acal_pkg::lane_ctl_t      ctl,
  input  logic signed [16:0]       value,
  input  logic signed [15:0]       offset,
  input  logic        [15:0]       divider,
  output logic signed [15:0]       level
);

  logic signed [33:0] prod;
  logic        [15:0] dvs;
  logic               neg;
  logic               ovf;
  logic        [15:0] rem;
  logic        [15:0] quo;

  logic signed [17:0] sum;
  logic signed [33:0] sum_ext;
  logic        [33:0] mag;
  logic        [15:0] rem_next;
  logic        [15:0] quo_next;
  logic        [16:0] neg_quo;

  assign sum     = {value[16], value} + {{2{offset[15]}}, offset};
  assign sum_ext = {{16{sum[17]}}, sum};
  assign mag     = prod[33] ? (34'd0 - prod) : prod;
  assign neg_quo = 17'd0 - {1'b0, quo};

  // four restoring steps per cycle
  always_comb begin
    logic [16:0] t;
    logic [15:0] r;
    logic [15:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < acal_pkg::StepBits; i++) begin
      t = {r, q[15]};
      q = {q[14:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        q[0] = 1'b1;
      end
      r = t[15:0];
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= (sum_ext <<< 15) - sum_ext;
      dvs  <= (divider == 16'd0) ? 16'd1 : divider;
    end
    if (ctl.init) begin
      neg <= prod[33];
      ovf <= {1'b0, mag[30:16]} >= dvs;
      rem <= {1'b0, mag[30:16]};
      quo <= mag[15:0];
    end
    if (ctl.step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  always_comb begin
    if (neg) begin
      if (ovf || quo > 16'd32768) begin
        level = acal_pkg::LevelMin;
      end else begin
        level = neg_quo[15:0];
      end
    end else begin
      if (ovf || quo > 16'd32767) begin
        level = acal_pkg::LevelMax;
      end else begin
        level = quo;
      end
    end
  end

endmodule

### src/acal_merge.sv
// merge stage: compares lane results with stored values and emits change events
module acal_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      commit,
  input  logic                      events_enabled,
  input  acal_pkg::level_vec_t      levels,
  output logic                      busy,
  output logic                      event_valid,
  input  logic                      event_stall,
  output logic [1:0]                axis_index,
  output logic signed [15:0]        axis_level,
  output logic                      final_event
);

  acal_pkg::level_vec_t             stored;
  acal_pkg::level_vec_t             lv;
  logic [acal_pkg::NumAxes-1:0]     pend;
  logic [acal_pkg::NumAxes-1:0]     chg;
  logic [acal_pkg::NumAxes-1:0]     sel;
  logic                             xfer;

  always_comb begin
    for (int a = 0; a < acal_pkg::NumAxes; a++) begin
      chg[a] = levels[a] != stored[a];
    end
  end

  // lowest pending axis goes first
  always_comb begin
    if (pend[0]) begin
      axis_index = 2'd0;
      sel        = 3'b001;
    end else if (pend[1]) begin
      axis_index = 2'd1;
      sel        = 3'b010;
    end else begin
      axis_index = 2'd2;
      sel        = 3'b100;
    end
  end

  assign busy        = pend != '0;
  assign event_valid = busy;
  assign axis_level  = lv[axis_index];
  assign final_event = (pend & ~sel) == '0;
  assign xfer        = event_valid && !event_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
      pend   <= '0;
    end else if (commit) begin
      stored <= levels;
      pend   <= events_enabled ? chg : '0;
    end else if (xfer) begin
      pend   <= pend & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      lv <= levels;
    end
  end

endmodule

### src/accel_axis_calibrate_change_events.sv
// top level of the accelerometer axis calibration and change event block
//
//   channel   direction  handshake                  payload
//   sample    in         sample_valid/sample_stall  raw_x, raw_y, raw_z
//   event     out        event_valid/event_stall    axis_index, axis_level, final_event
//   config    in         cfg_we                     cfg_index, cfg_data
//
// a sample is taken only once the last has committed: load with offset and scale,
// magnitude, the radix-16 divider steps each lane owns, then commit to the merge stage
// commit waits until the events of the previous sample have all been taken
// reset is synchronous: stored axis values clear, offsets 0, dividers 1000, events on
// events leave one per transfer, lowest axis first, and hold while event_stall is high
module accel_axis_calibrate_change_events (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic signed [15:0] raw_z,
  output logic               event_valid,
  input  logic               event_stall,
  output logic [1:0]         axis_index,
  output logic signed [15:0] axis_level,
  output logic               final_event,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  acal_pkg::state_t                  state;
  acal_pkg::state_t                  state_next;
  logic [acal_pkg::StepCntW-1:0]     cnt;
  logic [acal_pkg::StepCntW-1:0]     cnt_next;
  acal_pkg::lane_ctl_t               ctl;
  logic                              commit;
  logic                              busy;

  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic signed [15:0] offset_z;
  logic        [15:0] divider_x;
  logic        [15:0] divider_y;
  logic        [15:0] divider_z;
  logic               events_enabled;

  logic signed [16:0] rot0;
  logic signed [16:0] rot1;
  logic signed [16:0] rot2;
  acal_pkg::level_vec_t levels;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x       <= '0;
      offset_y       <= '0;
      offset_z       <= '0;
      divider_x      <= acal_pkg::DividerReset;
      divider_y      <= acal_pkg::DividerReset;
      divider_z      <= acal_pkg::DividerReset;
      events_enabled <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        acal_pkg::CfgOffsetX:  offset_x       <= cfg_data;
        acal_pkg::CfgOffsetY:  offset_y       <= cfg_data;
        acal_pkg::CfgOffsetZ:  offset_z       <= cfg_data;
        acal_pkg::CfgDividerX: divider_x      <= cfg_data;
        acal_pkg::CfgDividerY: divider_y      <= cfg_data;
        acal_pkg::CfgDividerZ: divider_z      <= cfg_data;
        acal_pkg::CfgEvents:   events_enabled <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // rotation
  assign rot0 = {raw_y[15], raw_y};
  assign rot1 = 17'sd0 - {raw_x[15], raw_x};
  assign rot2 = {raw_z[15], raw_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acal_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    ctl          = '0;
    commit       = 1'b0;
    sample_stall = 1'b1;
    case (state)
      acal_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          ctl.load   = 1'b1;
          state_next = acal_pkg::ST_ABS;
        end
      end
      acal_pkg::ST_ABS: begin
        ctl.init   = 1'b1;
        cnt_next   = '0;
        state_next = acal_pkg::ST_DIV;
      end
      acal_pkg::ST_DIV: begin
        ctl.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == acal_pkg::StepCntW'(acal_pkg::DivSteps - 1)) begin
          state_next = acal_pkg::ST_DONE;
        end
      end
      acal_pkg::ST_DONE: begin
        if (!busy) begin
          commit     = 1'b1;
          state_next = acal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = acal_pkg::ST_IDLE;
      end
    endcase
  end

  acal_lane u_lane0 (
    .clk     (clk),
    .ctl     (ctl),
    .value   (rot0),
    .offset  (offset_x),
    .divider (divider_x),
    .level   (levels[0])
  );

  acal_lane u_lane1 (
    .clk     (clk),
    .ctl     (ctl),
    .value   (rot1),
    .offset  (offset_y),
    .divider (divider_y),
    .level   (levels[1])
  );

  acal_lane u_lane2 (
    .clk     (clk),
    .ctl     (ctl),
    .value   (rot2),
    .offset  (offset_z),
    .divider (divider_z),
    .level   (levels[2])
  );

  acal_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .commit         (commit),
    .events_enabled (events_enabled),
    .levels         (levels),
    .busy           (busy),
    .event_valid    (event_valid),
    .event_stall    (event_stall),
    .axis_index     (axis_index),
    .axis_level     (axis_level),
    .final_event    (final_event)
  );

endmodule
